// File: hdl/kfc_pkg.sv
`timescale 1ns / 1ps

package kfc_pkg;

   // Field widths of the request and response words
   localparam int KEY_W      = 64;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 32;
   localparam int DISTINCT_W = 5;

   // Defaults for the top-level parameters
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int KEY_BITS_DEF    = 64;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [KEY_W-1:0] level_key;
      logic             end_of_log;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]     slot_index;
      logic [COUNT_W-1:0]    slot_count;
      logic [DISTINCT_W-1:0] distinct_keys;
      logic [KEY_W-1:0]      mode_key;
      logic [COUNT_W-1:0]    mode_count;
      logic                  table_overflow;
   } rsp_type;

endpackage

// File: hdl/kfc_ram.sv
`timescale 1ns / 1ps

module kfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/key_frequency_counter_with_mode.sv
`timescale 1ns / 1ps

// Key frequency counter with running mode.
// Request channel (req_valid / req_stall / req_data) takes one word per log
// entry: a packed level key and an end-of-log flag. Response channel
// (rsp_valid / rsp_stall / rsp_data) returns one word per request: the slot
// holding the key, its count, the number of distinct keys, the running mode
// key and count, and the sticky table overflow flag.
// Keys and counts live in one RAM with a registered read port. Each
// request is handled alone; the table is scanned one slot per cycle through
// the single read port. The response register is loaded as the block
// returns to idle, where the next request can be taken; a stalled response
// holds the block in its response state until the receiver takes the word,
// then a new request is accepted.
// Reset clears the slot count, mode and overflow flag at once; RAM contents
// are never read before they are written. An end-of-log request clears the
// same state after its response is loaded.
module key_frequency_counter_with_mode #(
   parameter int TABLE_DEPTH = kfc_pkg::TABLE_DEPTH_DEF,
   parameter int KEY_BITS    = kfc_pkg::KEY_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kfc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kfc_pkg::rsp_type rsp_data
);

   import kfc_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ENT_W = KEY_BITS + COUNT_W;
   localparam logic [CNT_W-1:0] USED_FULL = CNT_W'(TABLE_DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_type;

   state_type            state_ff,     state_in;
   logic [KEY_BITS-1:0]  key_ff,       key_in;
   logic                 last_ff,      last_in;
   logic [CNT_W-1:0]     rd_ptr_ff,    rd_ptr_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [CNT_W-1:0]     chk_idx_ff,   chk_idx_in;
   logic [CNT_W-1:0]     used_ff,      used_in;
   logic [KEY_BITS-1:0]  best_key_ff,  best_key_in;
   logic [COUNT_W-1:0]   best_cnt_ff,  best_cnt_in;
   logic                 ovf_ff,       ovf_in;
   logic [IDX_W-1:0]     res_idx_ff,   res_idx_in;
   logic [COUNT_W-1:0]   res_cnt_ff,   res_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff,  rsp_data_in;

   logic                 req_accept;
   logic                 issue_en;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENT_W-1:0]     wr_data;
   logic [ENT_W-1:0]     rd_data;
   logic [KEY_BITS-1:0]  rd_key;
   logic [COUNT_W-1:0]   rd_cnt;
   logic [COUNT_W-1:0]   inc_cnt;
   logic                 hit;
   logic                 scan_end;

   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);

   // Split the entry and form the saturating increment
   assign rd_key   = rd_data[KEY_BITS-1:0];
   assign rd_cnt   = rd_data[KEY_BITS +: COUNT_W];
   assign inc_cnt  = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_W'(1);
   assign hit      = chk_valid_ff && (rd_key == key_ff);
   assign scan_end = chk_valid_ff && (chk_idx_ff == used_ff - CNT_W'(1));
   assign issue_en = (state_ff == S_SCAN) && (rd_ptr_ff < used_ff);

   kfc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue_en),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Next-state logic: accept, scan with one read in flight, respond
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      rd_ptr_in    = rd_ptr_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      used_in      = used_ff;
      best_key_in  = best_key_ff;
      best_cnt_in  = best_cnt_ff;
      ovf_in       = ovf_ff;
      res_idx_in   = res_idx_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = used_ff[IDX_W-1:0];
      wr_data      = {COUNT_W'(1), key_ff};

      // Drop the response word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in    = req_data.level_key[KEY_BITS-1:0];
               last_in   = req_data.end_of_log;
               rd_ptr_in = '0;
               if (ovf_ff) begin
                  // Ignore the key while overflow is set
                  res_idx_in = '0;
                  res_cnt_in = '0;
                  state_in   = S_RESP;
               end else if (used_ff == '0) begin
                  // First key: store it and make it the mode
                  wr_en       = 1'b1;
                  wr_addr     = '0;
                  wr_data     = {COUNT_W'(1), req_data.level_key[KEY_BITS-1:0]};
                  used_in     = CNT_W'(1);
                  best_key_in = req_data.level_key[KEY_BITS-1:0];
                  best_cnt_in = COUNT_W'(1);
                  res_idx_in  = '0;
                  res_cnt_in  = COUNT_W'(1);
                  state_in    = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue the next read while the previous one is compared
            if (issue_en) begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            end
            chk_valid_in = issue_en;
            chk_idx_in   = rd_ptr_ff;
            if (hit) begin
               wr_en      = 1'b1;
               wr_addr    = chk_idx_ff[IDX_W-1:0];
               wr_data    = {inc_cnt, key_ff};
               res_idx_in = chk_idx_ff[IDX_W-1:0];
               res_cnt_in = inc_cnt;
               if (inc_cnt > best_cnt_ff) begin
                  best_cnt_in = inc_cnt;
                  best_key_in = key_ff;
               end
               chk_valid_in = 1'b0;
               state_in     = S_RESP;
            end else if (scan_end) begin
               if (used_ff == USED_FULL) begin
                  // New key with no room left
                  ovf_in     = 1'b1;
                  res_idx_in = '0;
                  res_cnt_in = '0;
               end else begin
                  wr_en      = 1'b1;
                  res_idx_in = used_ff[IDX_W-1:0];
                  res_cnt_in = COUNT_W'(1);
                  used_in    = used_ff + CNT_W'(1);
               end
               chk_valid_in = 1'b0;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            // Load the response once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.slot_index      = SLOT_W'(res_idx_ff);
               rsp_data_in.slot_count      = res_cnt_ff;
               rsp_data_in.distinct_keys   = DISTINCT_W'(used_ff);
               rsp_data_in.mode_key        = KEY_W'(best_key_ff);
               rsp_data_in.mode_count      = best_cnt_ff;
               rsp_data_in.table_overflow  = ovf_ff;
               if (last_ff) begin
                  used_in     = '0;
                  best_key_in = '0;
                  best_cnt_in = '0;
                  ovf_in      = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_valid_ff <= 1'b0;
         used_ff      <= '0;
         best_key_ff  <= '0;
         best_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         used_ff      <= used_in;
         best_key_ff  <= best_key_in;
         best_cnt_ff  <= best_cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      last_ff     <= last_in;
      rd_ptr_ff   <= rd_ptr_in;
      chk_idx_ff  <= chk_idx_in;
      res_idx_ff  <= res_idx_in;
      res_cnt_ff  <= res_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hdl/kfc_checker.sv
`timescale 1ns / 1ps

module kfc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input kfc_pkg::rsp_type rsp_data
);

   import kfc_pkg::*;

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // Take one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in flight");

   // Overflow reports slot index zero and a zero count
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_overflow |->
         rsp_data.slot_index == '0 && rsp_data.slot_count == '0)
      else $error("overflow response carries a slot or count");

   // Without overflow, the reported slot count is nonzero and bounded by the mode count
   a_mode_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.table_overflow |->
         rsp_data.slot_count != '0 && rsp_data.mode_count >= rsp_data.slot_count)
      else $error("slot count zero or above mode count");

endmodule

bind key_frequency_counter_with_mode kfc_checker u_kfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
